### hw/rtl/led_strip_fade_frame_engine_core_defines.svh
// Assertion macros used by the checker file.
`ifndef LED_STRIP_FADE_FRAME_ENGINE_CORE_DEFINES_SVH
`define LED_STRIP_FADE_FRAME_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LSFE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsfe check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LSFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsfe check failed");

`endif

### hw/rtl/lsfe_pkg.sv
package lsfe_pkg;

  // Request opcodes
  localparam logic OP_LIGHT   = 1'b0;
  localparam logic OP_REFRESH = 1'b1;

  // Display modes; any other code runs the fade effect
  localparam logic [1:0] MODE_EFFECT = 2'd0;
  localparam logic [1:0] MODE_GREEN  = 2'd1;
  localparam logic [1:0] MODE_BLUE   = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_DISPLAY_MODE = 3'd0;
  localparam logic [2:0] REG_RED_FULL     = 3'd1;
  localparam logic [2:0] REG_GREEN_FULL   = 3'd2;
  localparam logic [2:0] REG_BLUE_FULL    = 3'd3;
  localparam logic [2:0] REG_RED_FADE     = 3'd4;
  localparam logic [2:0] REG_GREEN_FADE   = 3'd5;
  localparam logic [2:0] REG_BLUE_FADE    = 3'd6;

  localparam logic [7:0] LEVEL_MAX = 8'hff;
  localparam logic [7:0] LEVEL_OFF = 8'h00;

  typedef struct packed {
    logic       opcode;
    logic [5:0] led_index;
  } in_req_t;

  typedef struct packed {
    logic [7:0] green_level;
    logic [7:0] red_level;
    logic [7:0] blue_level;
    logic       last_led;
  } out_rsp_t;

  // Stored entry layout
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  // Drop a channel to zero at or below step+1, else subtract the step
  function automatic logic [7:0] fade_level(input logic [7:0] level, input logic [7:0] step);
    logic [8:0] limit;
    limit = {1'b0, step} + 9'd1;
    if (level == LEVEL_OFF) begin
      fade_level = LEVEL_OFF;
    end else if ({1'b0, level} <= limit) begin
      fade_level = LEVEL_OFF;
    end else begin
      fade_level = level - step;
    end
  endfunction

endpackage

### hw/rtl/led_strip_fade_frame_engine_core.sv
// LED strip fade frame engine.
// Input channel (in_valid/in_ready/in_data): a light request writes the
// configured full color into one LED entry and returns nothing; an index at
// or beyond LED_COUNT is dropped. A refresh request streams
// LED_COUNT GRB results on out_valid/out_ready/out_data, LED 0 first, with
// last_led on the final one. The refresh is registered, then each entry is
// read into the memory read register and moved on into the output register;
// results follow one per cycle while the receiver does not stall. The rate
// is set by the single read port of the color memory: one entry per cycle.
// In effect mode each read entry is faded and written back through the
// write port in the cycle its result enters the output register.
// in_ready is low while a refresh still has entries to read or one pending;
// a new request is taken while the last result waits in the output register.
// When the receiver stalls, the read pipeline holds and nothing is lost.
// Reset (rst_n low, synchronous) clears the per-entry valid bits, so every
// LED reads as off, and loads the register defaults. Configuration writes
// (cfg_we/cfg_index/cfg_wdata) take effect at once and have no read-back.
module led_strip_fade_frame_engine_core
  import lsfe_pkg::*;
#(
  parameter int LED_COUNT = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data,
  input  logic     cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam int ADDR_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(LED_COUNT - 1);

  // Configuration registers
  logic [1:0] mode_r;
  logic [7:0] red_full_r, green_full_r, blue_full_r;
  logic [7:0] red_fade_r, green_fade_r, blue_fade_r;

  // Refresh pipeline control
  logic                 issue_busy_r;
  logic [ADDR_W-1:0]    rd_idx_r;
  logic                 rd_pend_r;
  logic                 rd_last_r;
  logic                 rd_vld_r;
  logic [ADDR_W-1:0]    wb_idx_r;
  logic [LED_COUNT-1:0] valid_r;
  logic                 out_valid_r;
  out_rsp_t             out_data_r;

  logic              in_accept;
  logic              light_ok;
  logic              move;
  logic              issue;
  logic              effect;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  color_t            ram_wdata;
  color_t            ram_rdata;
  color_t            entry;
  color_t            faded;
  out_rsp_t          out_nxt;

  // Color store
  lsfe_ram #(
    .WIDTH($bits(color_t)),
    .DEPTH(LED_COUNT)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (issue),
    .raddr(rd_idx_r),
    .rdata(ram_rdata)
  );

  // Handshake and pipeline advance
  assign in_ready  = !issue_busy_r && !rd_pend_r;
  assign in_accept = in_valid && in_ready;
  assign light_ok  = in_accept && (in_data.opcode == OP_LIGHT)
                     && ({1'b0, in_data.led_index} < 7'(LED_COUNT));
  assign move      = rd_pend_r && (!out_valid_r || out_ready);
  assign issue     = issue_busy_r && (!rd_pend_r || move);
  assign effect    = (mode_r != MODE_GREEN) && (mode_r != MODE_BLUE);

  // Entry that was never written reads as off
  assign entry = rd_vld_r ? ram_rdata : '0;

  always_comb begin
    faded.red   = fade_level(entry.red, red_fade_r);
    faded.green = fade_level(entry.green, green_fade_r);
    faded.blue  = fade_level(entry.blue, blue_fade_r);
  end

  // Write port: light request or fade write-back; the two never overlap,
  // and the write-back address always trails the read address
  always_comb begin
    ram_we    = light_ok || (move && effect);
    ram_waddr = wb_idx_r;
    ram_wdata = faded;
    if (light_ok) begin
      ram_waddr = in_data.led_index[ADDR_W-1:0];
      ram_wdata = '{red: red_full_r, green: green_full_r, blue: blue_full_r};
    end
  end

  // Build the result from the pending entry
  always_comb begin
    out_nxt.last_led = rd_last_r;
    case (mode_r)
      MODE_GREEN: begin
        out_nxt.green_level = LEVEL_MAX;
        out_nxt.red_level   = LEVEL_OFF;
        out_nxt.blue_level  = LEVEL_OFF;
      end
      MODE_BLUE: begin
        out_nxt.green_level = LEVEL_OFF;
        out_nxt.red_level   = LEVEL_OFF;
        out_nxt.blue_level  = LEVEL_MAX;
      end
      default: begin
        out_nxt.green_level = entry.green;
        out_nxt.red_level   = entry.red;
        out_nxt.blue_level  = entry.blue;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_EFFECT;
      red_full_r   <= LEVEL_MAX;
      green_full_r <= LEVEL_MAX;
      blue_full_r  <= LEVEL_MAX;
      red_fade_r   <= 8'd16;
      green_fade_r <= 8'd16;
      blue_fade_r  <= 8'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISPLAY_MODE: mode_r       <= cfg_wdata[1:0];
        REG_RED_FULL:     red_full_r   <= cfg_wdata;
        REG_GREEN_FULL:   green_full_r <= cfg_wdata;
        REG_BLUE_FULL:    blue_full_r  <= cfg_wdata;
        REG_RED_FADE:     red_fade_r   <= cfg_wdata;
        REG_GREEN_FADE:   green_fade_r <= cfg_wdata;
        REG_BLUE_FADE:    blue_fade_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Mark entries valid once written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[ram_waddr] <= 1'b1;
    end
  end

  // Read sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_busy_r <= 1'b0;
      rd_idx_r     <= '0;
      rd_pend_r    <= 1'b0;
    end else begin
      if (in_accept && (in_data.opcode == OP_REFRESH)) begin
        issue_busy_r <= 1'b1;
        rd_idx_r     <= '0;
      end
      if (issue) begin
        rd_idx_r  <= rd_idx_r + ADDR_W'(1);
        rd_pend_r <= 1'b1;
        if (rd_idx_r == LAST_IDX) begin
          issue_busy_r <= 1'b0;
        end
      end else if (move) begin
        rd_pend_r <= 1'b0;
      end
    end
  end

  // Track the entry sitting in the read register
  always_ff @(posedge clk) begin
    if (issue) begin
      wb_idx_r  <= rd_idx_r;
      rd_last_r <= (rd_idx_r == LAST_IDX);
      rd_vld_r  <= valid_r[rd_idx_r];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/lsfe_ram.sv
module lsfe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; hold the last word while not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/lsfe_checker.sv
`include "led_strip_fade_frame_engine_core_defines.svh"

module lsfe_checker
  import lsfe_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input in_req_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input out_rsp_t out_data
);

  // Hold a stalled result
  `LSFE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `LSFE_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))

  // Block new requests once a refresh starts
  `LSFE_ASSERT_NEXT(a_refresh_busy, in_valid && in_ready && (in_data.opcode == OP_REFRESH),
                    !in_ready)

  // Final result entering the output register means the read pipeline is drained
  `LSFE_ASSERT_NOW(a_last_drained, $rose(out_valid && out_data.last_led), in_ready)

endmodule

bind led_strip_fade_frame_engine_core lsfe_checker u_lsfe_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lsfe_pkg::*;

  localparam int LEDS = 64;
  localparam int SETTLE = 8;

  // Track the LED store and configuration, queue the expected GRB frames
  class led_frame_scoreboard;
    color_t     strip [LEDS];
    logic [1:0] mode;
    logic [7:0] full_r, full_g, full_b;
    logic [7:0] step_r, step_g, step_b;
    out_rsp_t   frame_leds [$];
    int         mismatches;

    function new();
      for (int i = 0; i < LEDS; i++) strip[i] = '0;
      mode = MODE_EFFECT;
      full_r = LEVEL_MAX;
      full_g = LEVEL_MAX;
      full_b = LEVEL_MAX;
      step_r = 8'd16;
      step_g = 8'd16;
      step_b = 8'd16;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        REG_DISPLAY_MODE: mode = val[1:0];
        REG_RED_FULL:     full_r = val;
        REG_GREEN_FULL:   full_g = val;
        REG_BLUE_FULL:    full_b = val;
        REG_RED_FADE:     step_r = val;
        REG_GREEN_FADE:   step_g = val;
        REG_BLUE_FADE:    step_b = val;
        default: ;
      endcase
    endfunction

    // Drop to off at or below step+1 (no wrap), else subtract the step
    function logic [7:0] faded(logic [7:0] lvl, logic [7:0] step);
      if (int'(lvl) <= int'(step) + 1) return LEVEL_OFF;
      return lvl - step;
    endfunction

    // Apply one accepted request: light an LED or queue a whole frame
    function void take_request(in_req_t req);
      out_rsp_t led;
      if (req.opcode == OP_LIGHT) begin
        if (int'(req.led_index) < LEDS) begin
          strip[req.led_index].red   = full_r;
          strip[req.led_index].green = full_g;
          strip[req.led_index].blue  = full_b;
        end
        return;
      end
      for (int i = 0; i < LEDS; i++) begin
        case (mode)
          MODE_GREEN: begin
            led.green_level = LEVEL_MAX;
            led.red_level   = LEVEL_OFF;
            led.blue_level  = LEVEL_OFF;
          end
          MODE_BLUE: begin
            led.green_level = LEVEL_OFF;
            led.red_level   = LEVEL_OFF;
            led.blue_level  = LEVEL_MAX;
          end
          default: begin
            led.green_level = strip[i].green;
            led.red_level   = strip[i].red;
            led.blue_level  = strip[i].blue;
            strip[i].red   = faded(strip[i].red, step_r);
            strip[i].green = faded(strip[i].green, step_g);
            strip[i].blue  = faded(strip[i].blue, step_b);
          end
        endcase
        led.last_led = (i == LEDS - 1);
        frame_leds.push_back(led);
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Match one accepted result against the oldest expected LED
    function void check_led(out_rsp_t got);
      out_rsp_t want;
      if (frame_leds.size() == 0) begin
        $display("%0t: result with nothing expected, expected none got %h", $time, got);
        mismatches++;
        return;
      end
      want = frame_leds.pop_front();
      compare_field("green_level", want.green_level, got.green_level);
      compare_field("red_level", want.red_level, got.red_level);
      compare_field("blue_level", want.blue_level, got.blue_level);
      compare_field("last_led", {7'b0, want.last_led}, {7'b0, got.last_led});
    endfunction

    function int outstanding();
      return frame_leds.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_req_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_rsp_t   out_data;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_DISPLAY_MODE;
  logic [7:0] cfg_wdata = '0;

  int send_idle = 14;
  int recv_idle = 57;

  led_frame_scoreboard sb = new();

  led_strip_fade_frame_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Stall the receiver at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Observe register writes and both handshakes
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
      if (in_valid && in_ready) sb.take_request(in_data);
      if (out_valid && out_ready) sb.check_led(out_data);
    end
  end

  // Offer one request, idling first at random; hold valid until taken
  task automatic send_request(logic op, logic [5:0] idx);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data.opcode <= op;
    in_data.led_index <= idx;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait out every expected LED, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all seven registers back to back
  task automatic write_regs(logic [1:0] mode, logic [7:0] fr, logic [7:0] fg,
                            logic [7:0] fb, logic [7:0] sr, logic [7:0] sg,
                            logic [7:0] sbl);
    logic [7:0] v [7];
    v[REG_DISPLAY_MODE] = {6'b0, mode};
    v[REG_RED_FULL]     = fr;
    v[REG_GREEN_FULL]   = fg;
    v[REG_BLUE_FULL]    = fb;
    v[REG_RED_FADE]     = sr;
    v[REG_GREEN_FADE]   = sg;
    v[REG_BLUE_FADE]    = sbl;
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= v[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Pick a setting: all high, all low, or random with mostly small fade steps
  task automatic program_setting(int kind);
    int m;
    case (kind)
      0: write_regs(MODE_EFFECT, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX,
                    LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
      1: write_regs(MODE_EFFECT, LEVEL_OFF, LEVEL_OFF, LEVEL_OFF,
                    LEVEL_OFF, LEVEL_OFF, LEVEL_OFF);
      default: begin
        m = $urandom_range(5);
        write_regs((m > 3) ? MODE_EFFECT : 2'(m),
                   8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(48)),
                   8'($urandom_range(48)), 8'($urandom_range(48)));
      end
    endcase
  endtask

  // Mix lights on random LEDs with refreshes
  task automatic run_random(int count);
    logic op;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(99) < 30) ? OP_REFRESH : OP_LIGHT;
      send_request(op, 6'($urandom_range(LEDS - 1)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: empty frame, both end LEDs, fade from full
    send_request(OP_REFRESH, 6'd0);
    send_request(OP_LIGHT, 6'd0);
    send_request(OP_LIGHT, 6'd63);
    send_request(OP_REFRESH, 6'd63);
    send_request(OP_REFRESH, 6'd0);
    drain();

    // Levels at the step+1 boundary, zero fade step on blue
    write_regs(MODE_EFFECT, 8'd17, 8'd18, 8'd1, 8'd16, 8'd16, 8'd0);
    send_request(OP_LIGHT, 6'd1);
    send_request(OP_LIGHT, 6'd62);
    send_request(OP_REFRESH, 6'd21);
    send_request(OP_REFRESH, 6'd42);
    drain();

    // Unused mode code runs the effect; largest fade step clears all
    write_regs(2'd3, 8'd0, 8'd255, 8'd128, 8'd255, 8'd255, 8'd255);
    send_request(OP_LIGHT, 6'd2);
    send_request(OP_REFRESH, 6'd0);
    send_request(OP_REFRESH, 6'd0);
    drain();

    // Solid green leaves the store alone while lights still land
    write_regs(MODE_GREEN, 8'd255, 8'd255, 8'd255, 8'd16, 8'd16, 8'd16);
    send_request(OP_LIGHT, 6'd3);
    send_request(OP_REFRESH, 6'd0);
    drain();

    write_regs(MODE_BLUE, 8'd255, 8'd255, 8'd255, 8'd16, 8'd16, 8'd16);
    send_request(OP_REFRESH, 6'd63);
    drain();

    // Back to the effect with a step just under the maximum
    write_regs(MODE_EFFECT, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254);
    send_request(OP_REFRESH, 6'd0);
    send_request(OP_LIGHT, 6'd42);
    send_request(OP_REFRESH, 6'd0);
    drain();

    // Random traffic under three idle patterns, four settings each
    for (int r = 0; r < 3; r++) begin
      case (r)
        0: begin send_idle = 14; recv_idle = 57; end
        1: begin send_idle = 57; recv_idle = 14; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int s = 0; s < 4; s++) begin
        program_setting(s);
        run_random(29);
        drain();
      end
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
